[hw/rtl/tdw_pkg.sv]
// Shared widths and constants for the ternary depth walk block.
package tdw_pkg;

  // Field widths of the input and result words.
  localparam int unsigned KEY_W     = 23;
  localparam int unsigned CNT_IN_W  = 4;
  localparam int unsigned DEP_IN_W  = 4;
  localparam int unsigned RANK_W    = 14;
  localparam int unsigned END_DEP_W = 5;

  // Default configuration of the walk.
  localparam int unsigned MAX_DIGITS_DEF      = 14;
  localparam int unsigned MAX_START_DEPTH_DEF = 15;

  // Division by three as a multiply by ceil(2^25 / 3) and a shift of 25.
  // Exact for every dividend below 2^24.
  localparam int unsigned      DIV3_RECIP_W = 24;
  localparam int unsigned      DIV3_SHIFT   = 25;
  localparam logic [23:0]      DIV3_RECIP   = 24'hAAAAAB;

  // Ternary symbol codes.
  localparam logic [1:0] SYM_NEUTRAL = 2'd0;
  localparam logic [1:0] SYM_DOWN    = 2'd1;
  localparam logic [1:0] SYM_UP      = 2'd2;

endpackage

[hw/rtl/tdw_in_if.sv]
// Input channel carrying one key word with its digit count and start depth.
interface tdw_in_if;
  logic                          valid;
  logic                          ready;
  logic [tdw_pkg::KEY_W-1:0]     key;
  logic [tdw_pkg::CNT_IN_W-1:0]  digit_count;
  logic [tdw_pkg::DEP_IN_W-1:0]  start_depth;

  modport source (output valid, output key, output digit_count, output start_depth,
                  input ready);
  modport sink   (input valid, input key, input digit_count, input start_depth,
                  output ready);
endinterface

[hw/rtl/tdw_out_if.sv]
// Result channel carrying the rank mask, final depth and halt flag.
interface tdw_out_if;
  logic                           valid;
  logic                           ready;
  logic [tdw_pkg::RANK_W-1:0]     rank_mask;
  logic [tdw_pkg::END_DEP_W-1:0]  end_depth;
  logic                           halted;

  modport source (output valid, output rank_mask, output end_depth, output halted,
                  input ready);
  modport sink   (input valid, input rank_mask, input end_depth, input halted,
                  output ready);
endinterface

[hw/rtl/tdw_div3.sv]
// Shared divide-by-three unit: quotient and ternary remainder of the key word.
module tdw_div3 (
  input  logic [tdw_pkg::KEY_W-1:0] dividend,
  output logic [tdw_pkg::KEY_W-1:0] quotient,
  output logic [1:0]                remainder
);

  localparam int unsigned PROD_W = tdw_pkg::KEY_W + tdw_pkg::DIV3_RECIP_W;

  logic [PROD_W-1:0]           prod;
  logic [tdw_pkg::KEY_W+1:0]   three_q;
  logic [tdw_pkg::KEY_W+1:0]   diff;

  always_comb begin
    prod      = PROD_W'(dividend) * PROD_W'(tdw_pkg::DIV3_RECIP);
    quotient  = tdw_pkg::KEY_W'(prod[PROD_W-1:tdw_pkg::DIV3_SHIFT]);
    // Three times the quotient by shift and add, then the remainder is what is left.
    three_q   = {1'b0, quotient, 1'b0} + {2'b00, quotient};
    diff      = {2'b00, dividend} - three_q;
    remainder = diff[1:0];
  end

endmodule

[hw/rtl/ternary_depth_walk_rank_mask.sv]
// Top level of the ternary depth walk: splits the key into digits, then walks them.
//
//   Channel   Direction  Handshake          Word contents
//   in_ch     sink       valid / ready      key, digit_count, start_depth
//   out_ch    source     valid / ready      rank_mask, end_depth, halted
//
// An accepted word goes through the split state, where the single divide-by-three unit
// peels off one digit per step, then the walk state, one step per digit, then the done
// state, which loads the result register. A halt ends the walk early, and a zero count
// goes straight to the result. The input is ready again only once the sequencer is back
// in idle, so a new word is taken only after the previous one has left the sequencer.
// Reset is synchronous and active low; it empties the result register and returns
// the sequencer to idle. A stalled result is held in the output register while the
// next input word is already accepted, so a stall only costs cycles once the walk
// of that next word has finished and finds the register still occupied.
module ternary_depth_walk_rank_mask #(
  parameter int unsigned MAX_DIGITS      = tdw_pkg::MAX_DIGITS_DEF,
  parameter int unsigned MAX_START_DEPTH = tdw_pkg::MAX_START_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tdw_in_if.sink    in_ch,
  tdw_out_if.source out_ch
);

  // Widths that follow from the parameters.
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned DEP_W = $clog2(MAX_START_DEPTH + MAX_DIGITS + 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SPLIT = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [tdw_pkg::KEY_W-1:0]   rest_r, rest_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [DEP_W-1:0]            depth_r, depth_nxt;
  logic [CNT_W-1:0]            ups_r, ups_nxt;
  logic [tdw_pkg::RANK_W-1:0]  mask_r, mask_nxt;
  logic                        halt_r, halt_nxt;

  // Digits of the key, least significant at index zero.
  logic [1:0]                  digits_r [MAX_DIGITS];

  logic                        out_valid_r, out_valid_nxt;
  logic [tdw_pkg::RANK_W-1:0]  out_mask_r;
  logic [tdw_pkg::END_DEP_W-1:0] out_depth_r;
  logic                        out_halt_r;

  logic [tdw_pkg::KEY_W-1:0]   div_quo;
  logic [1:0]                  div_rem;
  logic [1:0]                  cur_digit;
  logic [CNT_W-1:0]            in_count;
  logic [DEP_W-1:0]            in_depth;
  logic                        in_fire;
  logic                        load_out;
  logic [IDX_W-1:0]            last_idx;

  tdw_div3 u_div3 (
    .dividend  (rest_r),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign in_fire          = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.rank_mask = out_mask_r;
  assign out_ch.end_depth = out_depth_r;
  assign out_ch.halted    = out_halt_r;

  // The result register takes a new word when it is empty or being emptied.
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));
  assign cur_digit = digits_r[idx_r];

  // Saturate the count to the digit capacity and clamp the start depth into range.
  always_comb begin
    if (32'(in_ch.digit_count) > MAX_DIGITS) begin
      in_count = CNT_W'(MAX_DIGITS);
    end else begin
      in_count = CNT_W'(in_ch.digit_count);
    end
    if (in_ch.start_depth == '0) begin
      in_depth = DEP_W'(1);
    end else if (32'(in_ch.start_depth) > MAX_START_DEPTH) begin
      in_depth = DEP_W'(MAX_START_DEPTH);
    end else begin
      in_depth = DEP_W'(in_ch.start_depth);
    end
  end

  always_comb begin
    state_nxt = state_r;
    rest_nxt  = rest_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    depth_nxt = depth_r;
    ups_nxt   = ups_r;
    mask_nxt  = mask_r;
    halt_nxt  = halt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          rest_nxt  = in_ch.key;
          count_nxt = in_count;
          idx_nxt   = '0;
          depth_nxt = in_depth;
          ups_nxt   = '0;
          mask_nxt  = '0;
          halt_nxt  = 1'b0;
          // With nothing to walk the start depth is already the answer.
          state_nxt = (in_count == '0) ? ST_DONE : ST_SPLIT;
        end
      end

      ST_SPLIT: begin
        // One digit peeled off per cycle; the walk then starts from the top digit.
        rest_nxt = div_quo;
        if (idx_r == last_idx) begin
          state_nxt = ST_WALK;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_WALK: begin
        if (cur_digit == tdw_pkg::SYM_DOWN) begin
          if (depth_r == DEP_W'(1)) begin
            halt_nxt = 1'b1;
          end else begin
            depth_nxt = depth_r - DEP_W'(1);
          end
        end else if (cur_digit == tdw_pkg::SYM_UP) begin
          // An up symbol leaving depth one marks its rank among the up symbols.
          if (depth_r == DEP_W'(1)) begin
            for (int k = 0; k < tdw_pkg::RANK_W; k++) begin
              if (32'(ups_r) == k) begin
                mask_nxt[k] = 1'b1;
              end
            end
          end
          ups_nxt   = ups_r + CNT_W'(1);
          depth_nxt = depth_r + DEP_W'(1);
        end
        if (halt_nxt || idx_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end

      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the walk carry no reset; the sequencer loads them on acceptance.
  always_ff @(posedge clk) begin
    rest_r  <= rest_nxt;
    count_r <= count_nxt;
    idx_r   <= idx_nxt;
    depth_r <= depth_nxt;
    ups_r   <= ups_nxt;
    mask_r  <= mask_nxt;
    halt_r  <= halt_nxt;
    if (state_r == ST_SPLIT) begin
      digits_r[idx_r] <= div_rem;
    end
    if (load_out) begin
      out_mask_r  <= mask_r;
      out_depth_r <= tdw_pkg::END_DEP_W'(depth_r);
      out_halt_r  <= halt_r;
    end
  end

endmodule
